>>> src/bounded_list_deque_search_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded list deque search block
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_DEQUE_SEARCH_DEFINES_SVH
`define BOUNDED_LIST_DEQUE_SEARCH_DEFINES_SVH

// check cons in the same cycle as ante
`define BLDS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define BLDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/blds_pkg.sv
// ----------------------------------------------------------------------------
// blds_pkg
// Shared widths, codes, command/status bundles and ring index helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package blds_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned STAT_W = 3;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [SUM_W-1:0]         sum_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_SEARCH     = 3'd4,
    MODE_DUMP       = 3'd5
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE      = 3'd0,
    STAT_OVERFLOW  = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_FOUND     = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_DUMPED    = 3'd5
  } status_e;

  typedef struct packed {
    logic accept;
    logic issue;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic list_empty;
    logic issue_last;
    logic scan_search;
  } sts_t;

  function automatic idx_t ring_add(idx_t base, cnt_t off);
    sum_t s;
    s = sum_t'(base) + sum_t'(off);
    if (s >= sum_t'(DEPTH)) begin
      s = s - sum_t'(DEPTH);
    end
    return idx_t'(s);
  endfunction

  function automatic idx_t ring_inc(idx_t idx);
    return (idx == idx_t'(DEPTH - 1)) ? '0 : idx + idx_t'(1);
  endfunction

  function automatic idx_t ring_dec(idx_t idx);
    return (idx == '0) ? idx_t'(DEPTH - 1) : idx - idx_t'(1);
  endfunction

endpackage

`default_nettype wire

>>> src/blds_ctrl.sv
// ----------------------------------------------------------------------------
// blds_ctrl
// Controller: accepts commands and sequences the search and dump scans.
// ----------------------------------------------------------------------------
`default_nettype none

module blds_ctrl
  import blds_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MODE_W-1:0]  mode_i,
  input  sts_t               sts_i,
  output cmd_t               cmd_o,
  output logic               busy_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if ((mode_i == MODE_SEARCH || mode_i == MODE_DUMP) && !sts_i.list_empty) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.issue_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_d = sts_i.scan_search ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> src/blds_dpath.sv
// ----------------------------------------------------------------------------
// blds_dpath
// Datapath: entry memory, ring pointers, scan read stage, match holding
// register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module blds_dpath
  import blds_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [MODE_W-1:0]  mode_i,
  input  data_t              value_i,
  output logic               result_valid_o,
  output logic [STAT_W-1:0]  status_o,
  output pos_t               position_o,
  output data_t              entry_value_o,
  output logic               last_o
);

  data_t   mem_q [DEPTH];

  idx_t    front_q, front_d;
  cnt_t    count_q, count_d;
  idx_t    idx_q, idx_d;
  logic    scan_dump_q, scan_dump_d;
  data_t   key_q, key_d;

  logic    rd_vld_q;
  data_t   rd_data_q;
  pos_t    rd_pos_q, rd_pos_d;
  logic    rd_last_q;
  idx_t    rd_addr;

  logic    pend_vld_q, pend_vld_d;
  pos_t    pend_pos_q, pend_pos_d;

  logic    wr_en;
  idx_t    wr_addr;

  logic    out_vld_q, out_vld_d;
  status_e out_status_q, out_status_d;
  pos_t    out_pos_q, out_pos_d;
  data_t   out_val_q, out_val_d;
  logic    out_last_q, out_last_d;

  logic    list_empty;
  logic    list_full;
  logic    issue_last;

  assign list_empty = (count_q == '0);
  assign list_full  = (count_q == cnt_t'(DEPTH));
  assign issue_last = ((cnt_t'(idx_q) + cnt_t'(1)) == count_q);
  assign rd_addr    = ring_add(front_q, cnt_t'(idx_q));
  assign rd_pos_d   = pos_t'(idx_q) + pos_t'(1);

  assign sts_o.list_empty  = list_empty;
  assign sts_o.issue_last  = issue_last;
  assign sts_o.scan_search = !scan_dump_q;

  always_comb begin
    front_d      = front_q;
    count_d      = count_q;
    idx_d        = idx_q;
    scan_dump_d  = scan_dump_q;
    key_d        = key_q;
    pend_vld_d   = pend_vld_q;
    pend_pos_d   = pend_pos_q;
    wr_en        = 1'b0;
    wr_addr      = front_q;
    out_vld_d    = 1'b0;
    out_status_d = STAT_DONE;
    out_pos_d    = '0;
    out_val_d    = '0;
    out_last_d   = 1'b1;

    if (cmd_i.accept) begin
      case (mode_i)
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          out_vld_d = 1'b1;
          if (list_full) begin
            out_status_d = STAT_OVERFLOW;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + cnt_t'(1);
            if (mode_i == MODE_PUSH_FRONT) begin
              front_d = ring_dec(front_q);
              wr_addr = ring_dec(front_q);
            end else begin
              wr_addr = ring_add(front_q, count_q);
            end
          end
        end
        MODE_POP_FRONT, MODE_POP_BACK: begin
          out_vld_d = 1'b1;
          if (list_empty) begin
            out_status_d = STAT_EMPTY;
          end else begin
            count_d = count_q - cnt_t'(1);
            if (mode_i == MODE_POP_FRONT) begin
              front_d = ring_inc(front_q);
            end
          end
        end
        MODE_SEARCH, MODE_DUMP: begin
          if (list_empty) begin
            out_vld_d    = 1'b1;
            out_status_d = STAT_EMPTY;
          end else begin
            idx_d       = '0;
            scan_dump_d = (mode_i == MODE_DUMP);
            key_d       = value_i;
            pend_vld_d  = 1'b0;
          end
        end
        default: begin
          out_vld_d = 1'b1;
        end
      endcase
    end

    if (cmd_i.issue) begin
      idx_d = idx_q + idx_t'(1);
    end

    if (rd_vld_q) begin
      if (scan_dump_q) begin
        out_vld_d    = 1'b1;
        out_status_d = STAT_DUMPED;
        out_pos_d    = rd_pos_q;
        out_val_d    = rd_data_q;
        out_last_d   = rd_last_q;
      end else if (rd_data_q == key_q) begin
        pend_vld_d = 1'b1;
        pend_pos_d = rd_pos_q;
        if (pend_vld_q) begin
          out_vld_d    = 1'b1;
          out_status_d = STAT_FOUND;
          out_pos_d    = pend_pos_q;
          out_last_d   = 1'b0;
        end
      end
    end

    if (cmd_i.flush) begin
      out_vld_d = 1'b1;
      if (pend_vld_q) begin
        out_status_d = STAT_FOUND;
        out_pos_d    = pend_pos_q;
      end else begin
        out_status_d = STAT_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= value_i;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      scan_dump_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      scan_dump_q <= scan_dump_d;
      rd_vld_q    <= cmd_i.issue;
      pend_vld_q  <= pend_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    rd_pos_q     <= rd_pos_d;
    rd_last_q    <= issue_last;
    pend_pos_q   <= pend_pos_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_val_q    <= out_val_d;
    out_last_q   <= out_last_d;
  end

  assign result_valid_o = out_vld_q;
  assign status_o       = out_status_q;
  assign position_o     = out_pos_q;
  assign entry_value_o  = out_val_q;
  assign last_o         = out_last_q;

endmodule

`default_nettype wire

>>> src/bounded_list_deque_search.sv
// ----------------------------------------------------------------------------
// bounded_list_deque_search
// Bounded double-ended list of signed 32-bit values with search and dump.
//
// Command channel: mode_i and value_i are taken at a rising edge where
// start is high and busy is low. Result channel: each result beat is on
// status_o, position_o, entry_value_o and last_o for one cycle while
// result_valid_o is high; last_o marks the final beat of a command.
// The receiver cannot stall; every beat must be taken when shown.
// Push, remove, undefined modes and any command on an empty list give one
// beat in the cycle after acceptance, and busy stays low, so these run at
// one command per cycle. Search and dump walk the list through the entry
// memory's single read port, one entry per cycle, with busy high during the
// scan, the wait state and, for a search, the flush state. A dump's beats
// pass the scan read stage and result register; a search holds each match
// until the next match or the scan ends, so the last match carries last_o.
// Reset clears the list to empty and the front pointer to zero; entry
// storage is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_list_deque_search
  import blds_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [MODE_W-1:0]  mode_i,
  input  data_t              value_i,
  output logic               result_valid_o,
  output logic [STAT_W-1:0]  status_o,
  output pos_t               position_o,
  output data_t              entry_value_o,
  output logic               last_o
);

  cmd_t cmd;
  sts_t sts;

  blds_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mode_i  (mode_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  blds_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .position_o     (position_o),
    .entry_value_o  (entry_value_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

>>> src/blds_checker.sv
// ----------------------------------------------------------------------------
// blds_checker
// Port-level checks on command acceptance and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_list_deque_search_defines.svh"

module blds_checker
  import blds_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [MODE_W-1:0]  mode_i,
  input logic               result_valid_o,
  input logic [STAT_W-1:0]  status_o,
  input pos_t               position_o,
  input data_t              entry_value_o,
  input logic               last_o
);

  `BLDS_ASSERT_NEXT(a_single_beat, start && !busy && mode_i != MODE_SEARCH && mode_i != MODE_DUMP, result_valid_o && last_o && !busy, "single-beat command gave no final beat")
  `BLDS_ASSERT_NEXT(a_scan_start, start && !busy && (mode_i == MODE_SEARCH || mode_i == MODE_DUMP), busy != result_valid_o, "scan command neither busy nor answered")
  `BLDS_ASSERT_SAME(a_plain_last, result_valid_o && status_o != STAT_FOUND && status_o != STAT_DUMPED, last_o && position_o == '0 && entry_value_o == '0, "plain beat not final or not zeroed")
  `BLDS_ASSERT_SAME(a_pos_nonzero, result_valid_o && (status_o == STAT_FOUND || status_o == STAT_DUMPED), position_o != '0 && position_o <= pos_t'(DEPTH), "position out of range")

endmodule

bind bounded_list_deque_search blds_checker u_blds_checker (.*);

`default_nettype wire

>>> tb/tb_bounded_list_deque_search.sv
// ----------------------------------------------------------------------------
// tb_bounded_list_deque_search
// Self-checking bench for the bounded deque with search and dump. A directed
// sequence hits empty, full, extreme values and multi-match searches, then
// phased random traffic (push-heavy, pop-heavy or even) sweeps fill levels.
// A local ring model predicts every result beat and a monitor compares each
// beat in order against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bounded_list_deque_search;
  timeunit 1ns;
  timeprecision 1ps;

  import blds_pkg::*;

  localparam logic [MODE_W-1:0] MODE_RSVD_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD_B = 3'd7;
  localparam int unsigned RANDOM_CMDS    = 500;
  localparam int unsigned PHASE_LEN      = 50;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct {
    logic [MODE_W-1:0] mode;
    data_t             value;
    int unsigned       gap;
  } cmd_item_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    pos_t              position;
    data_t             entry_value;
    logic              last;
  } beat_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [MODE_W-1:0] mode_drv = '0;
  data_t             value_drv = '0;
  logic              result_valid_o;
  logic [STAT_W-1:0] status_o;
  pos_t              position_o;
  data_t             entry_value_o;
  logic              last_o;

  cmd_item_t   pending_cmds[$];
  beat_t       expected_beats[$];
  data_t       list_mem[DEPTH];
  int unsigned list_front = 0;
  int unsigned list_count = 0;
  int unsigned total_cmds = 0;
  int unsigned accepted_cmds = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left = 0;
  bit          quiet_stretch = 1'b0;

  bounded_list_deque_search dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_drv),
    .value_i        (value_drv),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .position_o     (position_o),
    .entry_value_o  (entry_value_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_beat(status_e s, int unsigned p, data_t v, logic l);
    beat_t b;
    b.status      = s;
    b.position    = pos_t'(p);
    b.entry_value = v;
    b.last        = l;
    expected_beats.push_back(b);
  endfunction

  function automatic void predict_beats(logic [MODE_W-1:0] mode, data_t value);
    int unsigned hits;
    beat_t       tail;
    hits = 0;
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (list_count >= DEPTH) begin
          add_beat(STAT_OVERFLOW, 0, '0, 1'b1);
        end else begin
          if (mode == MODE_PUSH_FRONT) begin
            list_front = (list_front + DEPTH - 1) % DEPTH;
            list_mem[list_front] = value;
          end else begin
            list_mem[(list_front + list_count) % DEPTH] = value;
          end
          list_count++;
          add_beat(STAT_DONE, 0, '0, 1'b1);
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (list_count == 0) begin
          add_beat(STAT_EMPTY, 0, '0, 1'b1);
        end else begin
          if (mode == MODE_POP_FRONT) begin
            list_front = (list_front + 1) % DEPTH;
          end
          list_count--;
          add_beat(STAT_DONE, 0, '0, 1'b1);
        end
      end
      MODE_SEARCH: begin
        if (list_count == 0) begin
          add_beat(STAT_EMPTY, 0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < list_count; i++) begin
            if (list_mem[(list_front + i) % DEPTH] == value) begin
              add_beat(STAT_FOUND, i + 1, '0, 1'b0);
              hits++;
            end
          end
          if (hits == 0) begin
            add_beat(STAT_NOT_FOUND, 0, '0, 1'b1);
          end else begin
            tail = expected_beats.pop_back();
            tail.last = 1'b1;
            expected_beats.push_back(tail);
          end
        end
      end
      MODE_DUMP: begin
        if (list_count == 0) begin
          add_beat(STAT_EMPTY, 0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < list_count; i++) begin
            add_beat(STAT_DUMPED, i + 1, list_mem[(list_front + i) % DEPTH],
                     (i == list_count - 1) ? 1'b1 : 1'b0);
          end
        end
      end
      default: begin
        add_beat(STAT_DONE, 0, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_stretch || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic data_t pick_value();
    data_t pool[8];
    pool = '{32'sd0, 32'sd1, -32'sd1, 32'sd5, 32'sd42, 32'sd7,
             32'h7fff_ffff, 32'h8000_0000};
    if ($urandom_range(0, 9) < 6) return pool[$urandom_range(0, 7)];
    return data_t'($urandom);
  endfunction

  function automatic void add_cmd(logic [MODE_W-1:0] mode, data_t value);
    cmd_item_t c;
    c.mode  = mode;
    c.value = value;
    c.gap   = pick_gap();
    pending_cmds.push_back(c);
    total_cmds++;
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(int unsigned push_pct,
                                                   int unsigned pop_pct);
    int unsigned r;
    bit          back;
    r    = $urandom_range(0, 99);
    back = $urandom_range(0, 1);
    if (r < push_pct) return back ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
    if (r < push_pct + pop_pct) return back ? MODE_POP_BACK : MODE_POP_FRONT;
    if (r < 86) return MODE_SEARCH;
    if (r < 95) return MODE_DUMP;
    return back ? MODE_RSVD_B : MODE_RSVD_A;
  endfunction

  function automatic void build_stimulus();
    data_t       v;
    int unsigned push_pct;
    int unsigned pop_pct;
    add_cmd(MODE_POP_FRONT, data_t'($urandom));
    add_cmd(MODE_POP_BACK, data_t'($urandom));
    add_cmd(MODE_SEARCH, 32'sd5);
    add_cmd(MODE_DUMP, data_t'($urandom));
    add_cmd(MODE_RSVD_A, data_t'($urandom));
    add_cmd(MODE_RSVD_B, data_t'($urandom));
    for (int unsigned i = 0; i < DEPTH; i++) begin
      case (i)
        0, 14, 15: v = 32'sd5;
        1:         v = 32'h8000_0000;
        2:         v = 32'h7fff_ffff;
        3:         v = 32'sd0;
        default:   v = data_t'($urandom);
      endcase
      add_cmd((i % 2 == 0) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, v);
    end
    add_cmd(MODE_PUSH_FRONT, 32'h7fff_ffff);
    add_cmd(MODE_PUSH_BACK, 32'h8000_0000);
    add_cmd(MODE_SEARCH, 32'sd5);
    add_cmd(MODE_SEARCH, 32'sd12345);
    add_cmd(MODE_DUMP, data_t'($urandom));
    for (int unsigned n = 0; n < RANDOM_CMDS; n++) begin
      if (n % PHASE_LEN == 0) begin
        quiet_stretch = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 2))
          0:       begin push_pct = 55; pop_pct = 15; end
          1:       begin push_pct = 15; pop_pct = 55; end
          default: begin push_pct = 35; pop_pct = 30; end
        endcase
      end
      add_cmd(pick_mode(push_pct, pop_pct), pick_value());
    end
  endfunction

  always @(posedge clk_i) begin : driver
    cmd_item_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        predict_beats(mode_drv, value_drv);
        accepted_cmds++;
      end
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          nxt = pending_cmds.pop_front();
          start     <= 1'b1;
          mode_drv  <= nxt.mode;
          value_drv <= nxt.value;
          gap_left  = nxt.gap;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    beat_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected beat: status=%0d pos=%0d value=%0d last=%0b",
                   status_o, position_o, entry_value_o, last_o);
        end
      end else begin
        want = expected_beats.pop_front();
        if (status_o !== want.status || position_o !== want.position ||
            entry_value_o !== want.entry_value || last_o !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("beat mismatch: exp status=%0d pos=%0d value=%0d last=%0b",
                     want.status, want.position, want.entry_value, want.last);
            $display("               got status=%0d pos=%0d value=%0d last=%0b",
                     status_o, position_o, entry_value_o, last_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (accepted_cmds < total_cmds) @(posedge clk_i);
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
